[src/life_grid_generation_step_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the life grid generation step block
// Concurrent checks, sampled on the rising clock edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life grid generation step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef logic [3:0] nbr_count_type;

   localparam nbr_count_type NBR_BIRTH   = 4'd3;
   localparam nbr_count_type NBR_SURVIVE = 4'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_STEP = 2'b10
   } state_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/lgs_row_cell.sv]
// ----------------------------------------------------------------------------
// lgs_row_cell
// One stage of the row chain: holds one grid row, loads a written row or
// takes its neighbor's row on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_cell #(
   parameter int COLS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lgs_pkg::cell_ctl_type ctl,
   input  wire logic [COLS-1:0]      wr_data,
   input  wire logic [COLS-1:0]      shift_in,
   output logic      [COLS-1:0]      row_q
);
   import lgs_pkg::*;

   logic [COLS-1:0] row_ff, row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.write) begin
         row_in = wr_data;
      end else if (ctl.shift) begin
         row_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

`default_nettype wire

[src/lgs_next_row.sv]
// ----------------------------------------------------------------------------
// lgs_next_row
// B3/S23 rule for one row: per-column neighbor count over three rows,
// dead cells beyond the left and right edges.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_next_row #(
   parameter int COLS = 32
) (
   input  wire logic [COLS-1:0] above_row,
   input  wire logic [COLS-1:0] center_row,
   input  wire logic [COLS-1:0] below_row,
   output logic      [COLS-1:0] next_row
);
   import lgs_pkg::*;

   logic [COLS+1:0] up_pad, mid_pad, dn_pad;

   assign up_pad  = {1'b0, above_row, 1'b0};
   assign mid_pad = {1'b0, center_row, 1'b0};
   assign dn_pad  = {1'b0, below_row, 1'b0};

   for (genvar c = 0; c < COLS; c++) begin : g_col
      nbr_count_type cnt;
      assign cnt = nbr_count_type'(up_pad[c])  + nbr_count_type'(up_pad[c+1])
                 + nbr_count_type'(up_pad[c+2]) + nbr_count_type'(mid_pad[c])
                 + nbr_count_type'(mid_pad[c+2]) + nbr_count_type'(dn_pad[c])
                 + nbr_count_type'(dn_pad[c+1]) + nbr_count_type'(dn_pad[c+2]);
      assign next_row[c] = (cnt == NBR_BIRTH) || (center_row[c] && (cnt == NBR_SURVIVE));
   end

endmodule

`default_nettype wire

[src/life_grid_generation_step_top.sv]
// ----------------------------------------------------------------------------
// life_grid_generation_step_top
// Bounded Game of Life grid held in a chain of row cells; a step rotates
// the chain through the rule logic and streams out the new generation.
// ----------------------------------------------------------------------------
//   channel   ports                                          handshake
//   request   req_op, req_row_index, req_row_cells           start & !busy
//   response  rsp_out_row_index, rsp_out_row_cells,
//             rsp_last_row                                   rsp_valid strobe
//
// A write transfer leaves busy low.
// A step holds busy while the row chain shifts, one row through the rule
// logic per cycle; each new row reaches the response ports in the next cycle.
// Reset clears the grid to all dead and returns to idle.
// Responses cannot be stalled; a new request may start while the last
// row is still on the response ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_grid_generation_step_top_defines.svh"

module life_grid_generation_step_top #(
   parameter int ROWS = 32,
   parameter int COLS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_op,
   input  wire logic [4:0]  req_row_index,
   input  wire logic [31:0] req_row_cells,
   output logic             rsp_valid,
   output logic [4:0]       rsp_out_row_index,
   output logic [31:0]      rsp_out_row_cells,
   output logic             rsp_last_row
);
   import lgs_pkg::*;

   localparam int RW = $clog2(ROWS);

   state_type       state_ff, state_in;
   logic [RW-1:0]   cnt_ff, cnt_in;
   logic [COLS-1:0] prev_ff, prev_in;
   logic [COLS-1:0] rows_q [ROWS];
   logic [COLS-1:0] below, next_row, wr_data;
   cell_ctl_type    ctl [ROWS];
   logic            accept, step_go, write_go, last_cnt;

   logic            rsp_valid_ff, rsp_last_ff;
   logic [4:0]      rsp_index_ff;
   logic [31:0]     rsp_cells_ff;

   assign busy     = (state_ff == ST_STEP);
   assign accept   = start && !busy;
   assign step_go  = accept && (req_op == OP_STEP);
   assign write_go = accept && (req_op == OP_WRITE);
   assign last_cnt = (cnt_ff == RW'(ROWS - 1));
   assign wr_data  = COLS'(req_row_cells);
   assign below    = last_cnt ? '0 : rows_q[1];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      case (state_ff)
         ST_IDLE: begin
            if (step_go) begin
               state_in = ST_STEP;
               cnt_in   = '0;
               prev_in  = '0;
            end
         end
         ST_STEP: begin
            prev_in = rows_q[0];
            cnt_in  = cnt_ff + RW'(1);
            if (last_cnt) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= busy;
         rsp_last_ff  <= busy && last_cnt;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (busy) begin
         rsp_index_ff <= 5'(cnt_ff);
         rsp_cells_ff <= 32'(next_row);
      end
   end

   lgs_next_row #(.COLS(COLS)) u_rule (
      .above_row  (prev_ff),
      .center_row (rows_q[0]),
      .below_row  (below),
      .next_row   (next_row)
   );

   for (genvar i = 0; i < ROWS; i++) begin : g_row
      logic [COLS-1:0] shift_in;

      assign ctl[i].shift = busy;
      assign ctl[i].write = write_go && (int'(req_row_index) == i);

      if (i == ROWS - 1) begin : g_tail
         assign shift_in = next_row;
      end else begin : g_body
         assign shift_in = rows_q[i+1];
      end

      lgs_row_cell #(.COLS(COLS)) u_row (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[i]),
         .wr_data  (wr_data),
         .shift_in (shift_in),
         .row_q    (rows_q[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_last_row      = rsp_last_ff;
   assign rsp_out_row_index = rsp_index_ff;
   assign rsp_out_row_cells = rsp_cells_ff;

   `LGS_ASSERT_NEXT(a_step_starts, clock, reset, step_go, busy, "step transfer did not start")
   `LGS_ASSERT_NEXT(a_busy_emits, clock, reset, busy, rsp_valid, "step cycle gave no row")
   `LGS_ASSERT_NOW(a_last_idle, clock, reset, rsp_last_row, rsp_valid && !busy,
                   "last row while still stepping")
   `LGS_ASSERT_NOW(a_rsp_from_step, clock, reset, rsp_valid, $past(busy),
                   "row emitted without a step")

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: life grid generation step testbench
// Writes rows into the 32 x 32 grid and steps it under the B3/S23 rule.
// A local copy of the grid predicts each new generation, and every streamed
// row is checked in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import lgs_pkg::*;

   localparam int ROWS         = 32;
   localparam int COLS         = 32;
   localparam int CLK_HALF     = 2;
   localparam int RESET_CYCLES = 12;
   localparam int SETTLE       = 8;
   localparam int MAX_GAP      = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_LIMIT  = 40;
   localparam logic [31:0] ROW_MASK = (COLS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COLS) - 32'd1);

   typedef struct {
      logic [4:0]  index;
      logic [31:0] cells;
      logic        last;
   } grid_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        req_op = OP_WRITE;
   logic [4:0]  req_row_index = '0;
   logic [31:0] req_row_cells = '0;
   logic        busy;
   logic        rsp_valid;
   logic [4:0]  rsp_out_row_index;
   logic [31:0] rsp_out_row_cells;
   logic        rsp_last_row;

   logic [31:0]  life_grid [ROWS] = '{default: '0};
   grid_row_type pending_rows [$];
   int           mismatch_count = 0;
   int           rows_checked = 0;
   int           writes_sent = 0;
   int           steps_sent = 0;
   int           cycle_count = 0;

   life_grid_generation_step_top #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_row_index(req_row_index),
      .req_row_cells(req_row_cells),
      .rsp_valid(rsp_valid),
      .rsp_out_row_index(rsp_out_row_index),
      .rsp_out_row_cells(rsp_out_row_cells),
      .rsp_last_row(rsp_last_row)
   );

   always #(CLK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rows still expected",
                  cycle_count, pending_rows.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic cell_alive(int r, int c);
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS)
         return 1'b0;
      return life_grid[r][c];
   endfunction

   // next generation; cells past the edge are dead
   function automatic void advance_generation();
      logic [31:0]   next_grid [ROWS];
      nbr_count_type live_nbrs;
      grid_row_type  row;
      for (int r = 0; r < ROWS; r++) begin
         next_grid[r] = '0;
         for (int c = 0; c < COLS; c++) begin
            live_nbrs = '0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0)
                     live_nbrs += nbr_count_type'(cell_alive(r + dr, c + dc));
            if (life_grid[r][c])
               next_grid[r][c] = (live_nbrs == NBR_SURVIVE) || (live_nbrs == NBR_BIRTH);
            else
               next_grid[r][c] = (live_nbrs == NBR_BIRTH);
         end
      end
      for (int r = 0; r < ROWS; r++) begin
         life_grid[r] = next_grid[r];
         row.index = 5'(r);
         row.cells = next_grid[r] & ROW_MASK;
         row.last  = (r == ROWS - 1);
         pending_rows.push_back(row);
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      grid_row_type want;
      if (!reset && rsp_valid) begin
         if (pending_rows.size() == 0) begin
            report_mismatch("row with none expected", rsp_out_row_cells, '0);
         end else begin
            want = pending_rows.pop_front();
            rows_checked++;
            if (rsp_out_row_index !== want.index)
               report_mismatch("row index", 32'(rsp_out_row_index), 32'(want.index));
            if (rsp_out_row_cells !== want.cells)
               report_mismatch($sformatf("cells of row %0d", want.index),
                               rsp_out_row_cells, want.cells);
            if (rsp_last_row !== want.last)
               report_mismatch($sformatf("last flag of row %0d", want.index),
                               32'(rsp_last_row), 32'(want.last));
         end
      end
   end

   // one transfer; start stays high so a following item can go back to back
   task automatic send_item(logic op, logic [4:0] idx, logic [31:0] cells);
      req_op        <= op;
      req_row_index <= idx;
      req_row_cells <= cells;
      start         <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (op == OP_STEP) begin
         steps_sent++;
         advance_generation();
      end else begin
         writes_sent++;
         if (idx < ROWS)
            life_grid[idx] = cells & ROW_MASK;
      end
   endtask

   task automatic sender_pause(int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         gap++;
      end
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      while (pending_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] random_row_cells();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom & $urandom;
         2:       return $urandom | $urandom;
         default: return 32'h7 << $urandom_range(29);
      endcase
   endfunction

   task automatic test_empty_grid();
      send_item(OP_STEP, 5'h1F, 32'hFFFF_FFFF);
   endtask

   // corners, full rows, blinker, alternating rows, glider
   task automatic test_edge_patterns();
      send_item(OP_WRITE, 5'd0,  32'h0000_0003);
      send_item(OP_WRITE, 5'd1,  32'hC000_0003);
      send_item(OP_WRITE, 5'd30, 32'hC000_0001);
      send_item(OP_WRITE, 5'd31, 32'h8000_0003);
      send_item(OP_WRITE, 5'd16, 32'h0001_C000);
      send_item(OP_STEP,  5'd0,  32'h0000_0000);
      send_item(OP_STEP,  5'd31, 32'h5555_5555);
      send_item(OP_WRITE, 5'd0,  32'hFFFF_FFFF);
      send_item(OP_WRITE, 5'd31, 32'hFFFF_FFFF);
      send_item(OP_WRITE, 5'd15, 32'h0000_0000);
      send_item(OP_STEP,  5'd10, 32'hAAAA_AAAA);
      send_item(OP_STEP,  5'd21, 32'h1234_5678);
      send_item(OP_WRITE, 5'd8,  32'hAAAA_AAAA);
      send_item(OP_WRITE, 5'd9,  32'h5555_5555);
      send_item(OP_WRITE, 5'd10, 32'hAAAA_AAAA);
      send_item(OP_STEP,  5'd9,  32'hFFFF_FFFF);
      send_item(OP_WRITE, 5'd2,  32'h0000_0004);
      send_item(OP_WRITE, 5'd3,  32'h0000_0008);
      send_item(OP_WRITE, 5'd4,  32'h0000_000E);
      send_item(OP_STEP,  5'd4,  32'h0000_000E);
   endtask

   task automatic test_pause_until_drained();
      send_item(OP_WRITE, 5'd20, 32'h0380_0000);
      send_item(OP_STEP, 5'($urandom), $urandom);
      hold_until_drained();
      send_item(OP_STEP, 5'($urandom), $urandom);
      send_item(OP_STEP, 5'($urandom), $urandom);
   endtask

   task automatic test_random_generations(int idle_pct, int n_items);
      for (int i = 0; i < n_items; i++) begin
         sender_pause(idle_pct);
         if ($urandom_range(99) < 22)
            send_item(OP_STEP, 5'($urandom), $urandom);
         else
            send_item(OP_WRITE, 5'($urandom_range(31)), random_row_cells());
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_grid();
      test_edge_patterns();
      test_random_generations(0, 40);
      test_pause_until_drained();
      test_random_generations(75, 35);
      test_random_generations(8, 30);
      hold_until_drained();
      $display("covered %0d row writes and %0d generation steps, %0d rows checked",
               writes_sent, steps_sent, rows_checked);
      $display("sender idling at 0, 8 and 75 percent, one full drain pause, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && pending_rows.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[life_grid_generation_step_top.f]
+incdir+src
src/lgs_pkg.sv
src/lgs_row_cell.sv
src/lgs_next_row.sv
src/life_grid_generation_step_top.sv
bench/tb_top.sv
